// ----- rtl/plbt_pkg.sv -----
// package for the price ladder best level tracker
// shared widths, request and config codes and word bit search functions; no dependencies
`default_nettype none
package plbt_pkg;

  localparam int unsigned LEVELS_DEF = 16384;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WORD_TOP   = 63;
  localparam int unsigned WORD_W     = 6;
  localparam int unsigned PRICE_W    = 48;
  localparam int unsigned QTY_W      = 48;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_PRICE = 1'b0,
    CFG_TICK_STEP  = 1'b1
  } cfg_e;

  function automatic logic [WORD_W-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [WORD_W-1:0] n;
    n = '0;
    for (int i = WORD_TOP; i >= 0; i--) begin
      if (w[i]) n = WORD_W'(i);
    end
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] high_bit(input logic [WORD_BITS-1:0] w);
    logic [WORD_W-1:0] n;
    n = '0;
    for (int i = 0; i <= WORD_TOP; i++) begin
      if (w[i]) n = WORD_W'(i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/plbt_ram.sv -----
// generic single write port ram with one registered read port
// depends on nothing
`default_nettype none
module plbt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/plbt_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// uses plbt_pkg; dividend must be below divisor times 2**QW
`default_nettype none
module plbt_div import plbt_pkg::*; #(
  parameter int unsigned QW = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [QW+STEP_W-1:0] dividend_i,
  input  wire logic [STEP_W-1:0]    divisor_i,
  output      logic                 done_o,
  output      logic [QW-1:0]        quot_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [STEP_W-1:0] rem_q, div_q;
  logic [QW-1:0]     low_q, quot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic [STEP_W:0]   trial;
  logic              fits;

  assign trial  = {rem_q, low_q[QW-1]};
  assign fits   = trial >= {1'b0, div_q};
  assign done_o = busy_q && (cnt_q == CNT_W'(1));
  assign quot_o = {quot_q[QW-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[QW+STEP_W-1:QW];
      low_q  <= dividend_i[QW-1:0];
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? STEP_W'(trial - {1'b0, div_q}) : STEP_W'(trial);
      low_q  <= {low_q[QW-2:0], 1'b0};
      quot_q <= {quot_q[QW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/price_ladder_best_level_tracker_top.sv -----
// set and read requests inside the price window run the divider, a level read and an update before the
// best level search; other requests go straight to the search, which ends early when no level is set
// clear request: sweep of the bitmap memories, then the result through S_DONE; one item at a time;
// the next item is taken while a result waits at the output; divider loop (one quotient bit per cycle)
// and the two bitmap tier reads set the rate; after reset the bitmap memories are swept with in_ready_o low
`default_nettype none
module price_ladder_best_level_tracker_top import plbt_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PRICE_W-1:0]   cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [PRICE_W-1:0]   price_i,
  input  wire logic [QTY_W-1:0]     qty_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic                 accepted_o,
  output      logic [QTY_W-1:0]     level_qty_o,
  output      logic [PRICE_W-1:0]   lowest_price_o,
  output      logic [PRICE_W-1:0]   highest_price_o
);

  localparam int unsigned LVL_W  = $clog2(LEVELS);
  localparam int unsigned CHUNKS = LEVELS / WORD_BITS;
  localparam int unsigned CW     = LVL_W - WORD_W;
  localparam int unsigned BLOCKS = CHUNKS / WORD_BITS;
  localparam int unsigned BLK_D  = (BLOCKS < 2) ? 2 : BLOCKS;
  localparam int unsigned BW     = $clog2(BLK_D);
  localparam int unsigned PROD_W = LVL_W + STEP_W;

  localparam logic [3:0] S_SWEEP = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_SB    = 4'd5;
  localparam logic [3:0] S_SC    = 4'd6;
  localparam logic [3:0] S_SL    = 4'd7;
  localparam logic [3:0] S_SP    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]          state_q;
  logic [PRICE_W-1:0]  base_q;
  logic [STEP_W-1:0]   step_q, step_eff;
  logic [CW-1:0]       sweep_q;
  logic                clr_q, side_q;
  logic [BLOCKS-1:0]   top_q;
  req_e                req_q;
  logic [QTY_W-1:0]    qty_q, rd_q;
  logic                acc_q;
  logic [LVL_W-1:0]    idx_q;
  logic [BW-1:0]       b_q, lo_b, hi_b;
  logic [CW-1:0]       c_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PRICE_W-1:0]  lo_q, hi_q;

  logic [PRICE_W:0]    diff, sum;
  logic                in_win;
  logic                div_start, div_done;
  logic [LVL_W-1:0]    quot;

  logic                lvl_we, chk_we, blk_we;
  logic [LVL_W-1:0]    lvl_addr;
  logic [CW-1:0]       chk_waddr, chk_raddr;
  logic [BW-1:0]       blk_waddr, blk_raddr;
  logic [63:0]         chk_wdata, blk_wdata, chk_rdata, blk_rdata;
  logic [QTY_W-1:0]    lvl_rdata;

  logic [WORD_W-1:0]   cb, bb;
  logic [CW-1:0]       idx_c;
  logic [BW-1:0]       idx_b;
  logic [63:0]         cw_new, bw_new;
  logic [WORD_W-1:0]   blk_enc, chk_enc;
  logic [PRICE_W-1:0]  price_sat;

  assign step_eff   = (step_q == '0) ? STEP_W'(1) : step_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign diff       = {1'b0, price_i} - {1'b0, base_q};
  assign in_win     = !diff[PRICE_W] &&
                      (diff[PRICE_W-1:0] < PRICE_W'({step_eff, {LVL_W{1'b0}}}));
  assign div_start  = in_ready_o && in_valid_i && in_win &&
                      (req_type_i == REQ_SET || req_type_i == REQ_READ);

  assign cb    = idx_q[WORD_W-1:0];
  assign idx_c = idx_q[LVL_W-1:WORD_W];
  assign idx_b = BW'(idx_c >> WORD_W);
  assign bb    = idx_c[WORD_W-1:0];

  always_comb begin
    lo_b = '0;
    hi_b = '0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (top_q[i]) lo_b = BW'(i);
    end
    for (int i = 0; i < BLOCKS; i++) begin
      if (top_q[i]) hi_b = BW'(i);
    end
  end

  assign blk_enc   = side_q ? high_bit(blk_rdata) : low_bit(blk_rdata);
  assign chk_enc   = side_q ? high_bit(chk_rdata) : low_bit(chk_rdata);
  assign sum       = {1'b0, base_q} + (PRICE_W+1)'(prod_q);
  assign price_sat = sum[PRICE_W] ? '1 : sum[PRICE_W-1:0];

  always_comb begin
    cw_new     = chk_rdata;
    cw_new[cb] = (qty_q != '0);
    bw_new     = blk_rdata;
    bw_new[bb] = (cw_new != '0);
  end

  always_comb begin
    lvl_we    = 1'b0;
    chk_we    = 1'b0;
    blk_we    = 1'b0;
    lvl_addr  = idx_q;
    chk_waddr = idx_c;
    chk_wdata = cw_new;
    blk_waddr = idx_b;
    blk_wdata = bw_new;
    chk_raddr = idx_c;
    blk_raddr = idx_b;
    unique case (state_q)
      S_SWEEP: begin
        chk_we    = 1'b1;
        blk_we    = 1'b1;
        chk_waddr = sweep_q;
        chk_wdata = '0;
        blk_waddr = BW'(sweep_q);
        blk_wdata = '0;
      end
      S_UPD: begin
        lvl_we = (req_q == REQ_SET);
        chk_we = (req_q == REQ_SET);
        blk_we = (req_q == REQ_SET);
      end
      S_SB: begin
        blk_raddr = side_q ? hi_b : lo_b;
      end
      S_SC: begin
        chk_raddr = (CW'(b_q) << WORD_W) | CW'(blk_enc);
      end
      default: begin
      end
    endcase
  end

  plbt_div #(.QW(LVL_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (PROD_W'(diff[PRICE_W-1:0])),
    .divisor_i  (step_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  plbt_ram #(.WIDTH(QTY_W), .DEPTH(LEVELS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_addr),
    .wdata_i (qty_q),
    .raddr_i (lvl_addr),
    .rdata_o (lvl_rdata)
  );

  plbt_ram #(.WIDTH(WORD_BITS), .DEPTH(CHUNKS)) u_chk_ram (
    .clk_i   (clk_i),
    .we_i    (chk_we),
    .waddr_i (chk_waddr),
    .wdata_i (chk_wdata),
    .raddr_i (chk_raddr),
    .rdata_o (chk_rdata)
  );

  plbt_ram #(.WIDTH(WORD_BITS), .DEPTH(BLK_D)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      step_q <= STEP_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_BASE_PRICE: base_q <= cfg_wdata_i;
        CFG_TICK_STEP:  step_q <= cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      clr_q       <= 1'b0;
      side_q      <= 1'b0;
      top_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != S_DONE) out_valid_o <= 1'b0;
      unique case (state_q)
        S_SWEEP: begin
          sweep_q <= sweep_q + CW'(1);
          if (sweep_q == CW'(CHUNKS - 1)) begin
            state_q <= clr_q ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            side_q <= 1'b0;
            if (req_type_i == REQ_CLEAR) begin
              clr_q   <= 1'b1;
              sweep_q <= '0;
              top_q   <= '0;
              state_q <= S_SWEEP;
            end else if (div_start) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_SB;
            end
          end
        end
        S_DIV: begin
          if (div_done) state_q <= S_RD;
        end
        S_RD: state_q <= S_UPD;
        S_UPD: begin
          if (req_q == REQ_SET) top_q[idx_b] <= (bw_new != '0);
          state_q <= S_SB;
        end
        S_SB: state_q <= (top_q == '0) ? S_DONE : S_SC;
        S_SC: state_q <= S_SL;
        S_SL: state_q <= S_SP;
        S_SP: begin
          side_q  <= 1'b1;
          state_q <= side_q ? S_DONE : S_SB;
        end
        S_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            clr_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        req_q <= req_e'(req_type_i);
        qty_q <= qty_i;
        rd_q  <= '0;
        lo_q  <= '0;
        hi_q  <= '0;
        acc_q <= (req_type_i == REQ_CLEAR) ||
                 (in_win && (req_type_i == REQ_SET || req_type_i == REQ_READ));
      end
      S_DIV: begin
        if (div_done) idx_q <= quot;
      end
      S_UPD: begin
        if (req_q == REQ_READ) rd_q <= chk_rdata[cb] ? lvl_rdata : '0;
      end
      S_SB: b_q <= side_q ? hi_b : lo_b;
      S_SC: c_q <= (CW'(b_q) << WORD_W) | CW'(blk_enc);
      S_SL: prod_q <= PROD_W'({c_q, chk_enc}) * PROD_W'(step_eff);
      S_SP: begin
        if (side_q) hi_q <= price_sat;
        else lo_q <= price_sat;
      end
      S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          accepted_o      <= acc_q;
          level_qty_o     <= rd_q;
          lowest_price_o  <= lo_q;
          highest_price_o <= hi_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/plbt_checker.sv -----
// port level checks for the price ladder best level tracker, bound to the top level
// uses plbt_pkg widths; depends on price_ladder_best_level_tracker_top
`default_nettype none
module plbt_checker import plbt_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               accepted_o,
  input wire logic [QTY_W-1:0]   level_qty_o,
  input wire logic [PRICE_W-1:0] lowest_price_o,
  input wire logic [PRICE_W-1:0] highest_price_o
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while another is in flight");

  a_reject_no_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> level_qty_o == '0)
    else $error("rejected item carries a quantity");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> lowest_price_o <= highest_price_o)
    else $error("lowest price above highest price");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(lowest_price_o))
    else $error("stalled result changed");

endmodule

bind price_ladder_best_level_tracker_top plbt_checker u_plbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .accepted_o      (accepted_o),
  .level_qty_o     (level_qty_o),
  .lowest_price_o  (lowest_price_o),
  .highest_price_o (highest_price_o)
);
`default_nettype wire
